@@ rtl/rjrf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rjrf_pkg;

   // distance and accumulator widths
   localparam int DIST_BITS   = 16;
   localparam int CNT_BITS    = 4;
   localparam int SUM_BITS    = DIST_BITS + CNT_BITS;
   localparam int CFG_MM_BITS = 16;
   localparam int PROD_BITS   = (SUM_BITS > CFG_MM_BITS + CNT_BITS) ?
                                SUM_BITS : CFG_MM_BITS + CNT_BITS;
   localparam int ALU_BITS    = PROD_BITS + 1;
   localparam int REM_BITS    = CNT_BITS + 1;
   localparam int STEP_BITS   = $clog2(SUM_BITS);
   localparam int MUL_IDX_BITS = $clog2(CNT_BITS);
   localparam int STATUS_BITS = 8;

   // configuration port
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_CHANGE   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAND_TOL     = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ACCEPT_COUNT = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FAIL_LIMIT   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_HELD     = 3'd4;

   localparam logic [CFG_MM_BITS-1:0] RST_MAX_CHANGE   = 16'd166;
   localparam logic [CFG_MM_BITS-1:0] RST_CAND_TOL     = 16'd200;
   localparam logic [CNT_BITS-1:0]    RST_ACCEPT_COUNT = 4'd10;
   localparam logic [CNT_BITS-1:0]    RST_FAIL_LIMIT   = 4'd10;
   localparam logic [CFG_MM_BITS-1:0] RST_MIN_HELD     = 16'd10;

   localparam logic [STATUS_BITS-1:0] STATUS_STALE = 8'd255;
   localparam logic [STATUS_BITS-1:0] STATUS_GOOD  = 8'd0;

   // shared unit operation
   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic                   read_ok;
      logic [DIST_BITS-1:0]   range_mm;
      logic [STATUS_BITS-1:0] range_status;
   } req_type;

   typedef struct packed {
      logic [DIST_BITS-1:0]   held_range_mm;
      logic                   report;
      logic [STATUS_BITS-1:0] report_status;
      logic                   accepted;
      logic                   jump_rejected;
      logic                   jump_adopted;
      logic                   disabled;
   } rsp_type;

   typedef struct packed {
      logic [CFG_MM_BITS-1:0] max_change_mm;
      logic [CFG_MM_BITS-1:0] candidate_tolerance_mm;
      logic [CNT_BITS-1:0]    jump_accept_count;
      logic [CNT_BITS-1:0]    fail_limit;
      logic [CFG_MM_BITS-1:0] min_held_mm;
   } cfg_type;

   typedef struct packed {
      logic idle;
      logic done;
   } core_status_type;

   // zero extension onto the shared unit width
   function automatic logic [ALU_BITS-1:0] ext_dist(logic [DIST_BITS-1:0] v);
      return {{(ALU_BITS-DIST_BITS){1'b0}}, v};
   endfunction

   function automatic logic [ALU_BITS-1:0] ext_mm(logic [CFG_MM_BITS-1:0] v);
      return {{(ALU_BITS-CFG_MM_BITS){1'b0}}, v};
   endfunction

   function automatic logic [ALU_BITS-1:0] ext_sum(logic [SUM_BITS-1:0] v);
      return {{(ALU_BITS-SUM_BITS){1'b0}}, v};
   endfunction

   function automatic logic [ALU_BITS-1:0] ext_rem(logic [REM_BITS-1:0] v);
      return {{(ALU_BITS-REM_BITS){1'b0}}, v};
   endfunction

endpackage

`default_nettype wire

@@ rtl/range_jump_rejection_filter_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Range jump rejection filter: one word per sensor read goes in, one result word
// comes out. Words are handled one at a time; failed, invalid or disabled reads need
// no arithmetic, and all other arithmetic is done by the single shared adder/subtractor
// that does the step compare, the 4-step shift-add products for the candidate test
// and the 20-step restoring divide for the candidate mean. A finished result sits in
// the output register, so the next word is taken while it waits. The user must write
// configuration registers through the csr port only while the block is idle; the
// block itself does not enforce this.
module range_jump_rejection_filter_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  rjrf_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output rjrf_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [rjrf_pkg::CSR_IDX_BITS-1:0]    csr_idx,
   input  logic [rjrf_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import rjrf_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;
   core_status_type core_status;
   rsp_type         core_result;
   logic            start;
   logic            out_free;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_idx)
            CSR_MAX_CHANGE:   cfg_in.max_change_mm          = csr_data[CFG_MM_BITS-1:0];
            CSR_CAND_TOL:     cfg_in.candidate_tolerance_mm = csr_data[CFG_MM_BITS-1:0];
            CSR_ACCEPT_COUNT: cfg_in.jump_accept_count      = csr_data[CNT_BITS-1:0];
            CSR_FAIL_LIMIT:   cfg_in.fail_limit             = csr_data[CNT_BITS-1:0];
            CSR_MIN_HELD:     cfg_in.min_held_mm            = csr_data[CFG_MM_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_change_mm          <= RST_MAX_CHANGE;
         cfg_ff.candidate_tolerance_mm <= RST_CAND_TOL;
         cfg_ff.jump_accept_count      <= RST_ACCEPT_COUNT;
         cfg_ff.fail_limit             <= RST_FAIL_LIMIT;
         cfg_ff.min_held_mm            <= RST_MIN_HELD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input handshake
   assign req_ready = core_status.idle;
   assign start     = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   rjrf_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .start    (start),
      .item     (req_data),
      .out_free (out_free),
      .status   (core_status),
      .result   (core_result)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (core_status.done && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ rtl/rjrf_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rjrf_alu (
   input  logic [rjrf_pkg::ALU_BITS-1:0] a,
   input  logic [rjrf_pkg::ALU_BITS-1:0] b,
   input  rjrf_pkg::alu_op_type          op,
   output logic [rjrf_pkg::ALU_BITS-1:0] res,
   output logic                          lt
);
   import rjrf_pkg::*;

   logic              is_sub;
   logic [ALU_BITS:0] full;

   // one adder serves add, subtract and unsigned compare
   assign is_sub = (op == ALU_SUB);
   assign full   = {1'b0, a} + {1'b0, (is_sub ? ~b : b)} + {{ALU_BITS{1'b0}}, is_sub};
   assign res    = full[ALU_BITS-1:0];
   // borrow out of the subtract means a < b
   assign lt     = is_sub & ~full[ALU_BITS];

endmodule

`default_nettype wire

@@ rtl/rjrf_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rjrf_core (
   input  logic                      clock,
   input  logic                      reset,
   input  rjrf_pkg::cfg_type         cfg,
   input  logic                      start,
   input  rjrf_pkg::req_type         item,
   input  logic                      out_free,
   output rjrf_pkg::core_status_type status,
   output rjrf_pkg::rsp_type         result
);
   import rjrf_pkg::*;

   typedef enum logic [12:0] {
      ST_IDLE      = 13'b0000000000001,
      ST_EVAL      = 13'b0000000000010,
      ST_DIFF      = 13'b0000000000100,
      ST_DIFF_NEG  = 13'b0000000001000,
      ST_STEP_CMP  = 13'b0000000010000,
      ST_MUL_D     = 13'b0000000100000,
      ST_MUL_T     = 13'b0000001000000,
      ST_JDIFF     = 13'b0000010000000,
      ST_JDIFF_NEG = 13'b0000100000000,
      ST_JCMP      = 13'b0001000000000,
      ST_ADD       = 13'b0010000000000,
      ST_DIV       = 13'b0100000000000,
      ST_DONE      = 13'b1000000000000
   } state_type;

   state_type              state_ff, state_in;
   req_type                item_ff, item_in;
   logic [DIST_BITS-1:0]   held_ff, held_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [CNT_BITS-1:0]    err_ff, err_in;
   logic                   dis_ff, dis_in;
   logic [ALU_BITS-1:0]    acc_ff, acc_in;
   logic [ALU_BITS-1:0]    tmp_ff, tmp_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic [REM_BITS-1:0]    rem_ff, rem_in;
   logic [REM_BITS-1:0]    div_ff, div_in;
   logic [SUM_BITS-1:0]    quo_ff, quo_in;
   logic                   rpt_en_ff, rpt_en_in;
   logic [STATUS_BITS-1:0] rstatus_ff, rstatus_in;
   logic                   accepted_ff, accepted_in;
   logic                   rejected_ff, rejected_in;
   logic                   adopted_ff, adopted_in;

   logic [ALU_BITS-1:0]     alu_a, alu_b, alu_res;
   alu_op_type              alu_op;
   logic                    alu_lt;
   logic [MUL_IDX_BITS-1:0] mul_idx;
   logic                    held_gt_min;
   logic                    valid_rd;
   logic [CNT_BITS-1:0]     err_next;
   logic [CNT_BITS-1:0]     cnt_next;
   logic [REM_BITS-1:0]     div_part;
   logic [SUM_BITS-1:0]     div_quo;

   rjrf_alu u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .op  (alu_op),
      .res (alu_res),
      .lt  (alu_lt)
   );

   assign mul_idx     = step_ff[MUL_IDX_BITS-1:0];
   assign held_gt_min = ext_dist(held_ff) > ext_mm(cfg.min_held_mm);
   assign valid_rd    = (item_ff.range_status == STATUS_GOOD) && (item_ff.range_mm != '0);
   assign err_next    = (err_ff == '1) ? err_ff : err_ff + CNT_BITS'(1);
   assign cnt_next    = cnt_ff + CNT_BITS'(1);
   assign div_part    = {rem_ff[REM_BITS-2:0], quo_ff[SUM_BITS-1]};
   assign div_quo     = {quo_ff[SUM_BITS-2:0], ~alu_lt};

   // operand selection for the shared unit
   always_comb begin
      alu_a  = '0;
      alu_b  = '0;
      alu_op = ALU_ADD;
      case (state_ff)
         ST_DIFF: begin
            alu_a  = ext_dist(item_ff.range_mm);
            alu_b  = ext_dist(held_ff);
            alu_op = ALU_SUB;
         end
         ST_DIFF_NEG: begin
            alu_a  = ext_dist(held_ff);
            alu_b  = ext_dist(item_ff.range_mm);
            alu_op = ALU_SUB;
         end
         ST_STEP_CMP: begin
            alu_a  = ext_mm(cfg.max_change_mm);
            alu_b  = tmp_ff;
            alu_op = ALU_SUB;
         end
         ST_MUL_D: begin
            alu_a = acc_ff;
            alu_b = cnt_ff[mul_idx] ? (ext_dist(item_ff.range_mm) << mul_idx) : '0;
         end
         ST_MUL_T: begin
            alu_a = tmp_ff;
            alu_b = cnt_ff[mul_idx] ? (ext_mm(cfg.candidate_tolerance_mm) << mul_idx) : '0;
         end
         ST_JDIFF: begin
            alu_a  = acc_ff;
            alu_b  = ext_sum(sum_ff);
            alu_op = ALU_SUB;
         end
         ST_JDIFF_NEG: begin
            alu_a  = ext_sum(sum_ff);
            alu_b  = acc_ff;
            alu_op = ALU_SUB;
         end
         ST_JCMP: begin
            alu_a  = acc_ff;
            alu_b  = tmp_ff;
            alu_op = ALU_SUB;
         end
         ST_ADD: begin
            alu_a = ext_sum(sum_ff);
            alu_b = ext_dist(item_ff.range_mm);
         end
         ST_DIV: begin
            alu_a  = ext_rem(div_part);
            alu_b  = ext_rem(div_ff);
            alu_op = ALU_SUB;
         end
         default: begin
            alu_a  = '0;
            alu_b  = '0;
            alu_op = ALU_ADD;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      held_in     = held_ff;
      cnt_in      = cnt_ff;
      sum_in      = sum_ff;
      err_in      = err_ff;
      dis_in      = dis_ff;
      acc_in      = acc_ff;
      tmp_in      = tmp_ff;
      step_in     = step_ff;
      rem_in      = rem_ff;
      div_in      = div_ff;
      quo_in      = quo_ff;
      rpt_en_in   = rpt_en_ff;
      rstatus_in  = rstatus_ff;
      accepted_in = accepted_ff;
      rejected_in = rejected_ff;
      adopted_in  = adopted_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in  = item;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            accepted_in = 1'b0;
            rejected_in = 1'b0;
            adopted_in  = 1'b0;
            rpt_en_in   = 1'b0;
            rstatus_in  = STATUS_STALE;
            state_in    = ST_DONE;
            if (dis_ff) begin
               // frozen until reset
               state_in = ST_DONE;
            end else if (!item_ff.read_ok) begin
               err_in = err_next;
               if (err_next >= cfg.fail_limit) begin
                  dis_in = 1'b1;
               end
            end else begin
               err_in    = '0;
               rpt_en_in = 1'b1;
               if (valid_rd) begin
                  rstatus_in = item_ff.range_status;
                  if (held_gt_min) begin
                     state_in = ST_DIFF;
                  end else begin
                     held_in     = item_ff.range_mm;
                     cnt_in      = '0;
                     sum_in      = '0;
                     accepted_in = 1'b1;
                  end
               end
            end
         end
         // absolute step from the held distance
         ST_DIFF: begin
            if (alu_lt) begin
               state_in = ST_DIFF_NEG;
            end else begin
               tmp_in   = alu_res;
               state_in = ST_STEP_CMP;
            end
         end
         ST_DIFF_NEG: begin
            tmp_in   = alu_res;
            state_in = ST_STEP_CMP;
         end
         ST_STEP_CMP: begin
            if (alu_lt) begin
               // jump: start a new candidate, or test against the running one
               if (cnt_ff == '0) begin
                  if (cfg.candidate_tolerance_mm != '0) begin
                     state_in = ST_ADD;
                  end else begin
                     cnt_in      = CNT_BITS'(1);
                     sum_in      = {{(SUM_BITS-DIST_BITS){1'b0}}, item_ff.range_mm};
                     rejected_in = 1'b1;
                     state_in    = ST_DONE;
                  end
               end else begin
                  acc_in   = '0;
                  tmp_in   = '0;
                  step_in  = '0;
                  state_in = ST_MUL_D;
               end
            end else begin
               held_in     = item_ff.range_mm;
               cnt_in      = '0;
               sum_in      = '0;
               accepted_in = 1'b1;
               state_in    = ST_DONE;
            end
         end
         // shift-add products d*n and tol*n
         ST_MUL_D: begin
            acc_in = alu_res;
            if (step_ff == STEP_BITS'(CNT_BITS-1)) begin
               step_in  = '0;
               state_in = ST_MUL_T;
            end else begin
               step_in = step_ff + STEP_BITS'(1);
            end
         end
         ST_MUL_T: begin
            tmp_in = alu_res;
            if (step_ff == STEP_BITS'(CNT_BITS-1)) begin
               step_in  = '0;
               state_in = ST_JDIFF;
            end else begin
               step_in = step_ff + STEP_BITS'(1);
            end
         end
         ST_JDIFF: begin
            if (alu_lt) begin
               state_in = ST_JDIFF_NEG;
            end else begin
               acc_in   = alu_res;
               state_in = ST_JCMP;
            end
         end
         ST_JDIFF_NEG: begin
            acc_in   = alu_res;
            state_in = ST_JCMP;
         end
         ST_JCMP: begin
            if (alu_lt) begin
               state_in = ST_ADD;
            end else begin
               cnt_in      = CNT_BITS'(1);
               sum_in      = {{(SUM_BITS-DIST_BITS){1'b0}}, item_ff.range_mm};
               rejected_in = 1'b1;
               state_in    = ST_DONE;
            end
         end
         // join the candidate, adopt once enough jumps agree
         ST_ADD: begin
            sum_in = alu_res[SUM_BITS-1:0];
            cnt_in = cnt_next;
            if ((cnt_next >= cfg.jump_accept_count) || (cnt_next == '0)) begin
               quo_in   = alu_res[SUM_BITS-1:0];
               rem_in   = '0;
               div_in   = (cnt_next == '0) ? {1'b1, {CNT_BITS{1'b0}}} : {1'b0, cnt_next};
               step_in  = '0;
               state_in = ST_DIV;
            end else begin
               rejected_in = 1'b1;
               state_in    = ST_DONE;
            end
         end
         // restoring divide, one quotient bit per cycle
         ST_DIV: begin
            quo_in = div_quo;
            rem_in = alu_lt ? div_part : alu_res[REM_BITS-1:0];
            if (step_ff == STEP_BITS'(SUM_BITS-1)) begin
               held_in     = div_quo[DIST_BITS-1:0];
               cnt_in      = '0;
               sum_in      = '0;
               accepted_in = 1'b1;
               adopted_in  = 1'b1;
               state_in    = ST_DONE;
            end else begin
               step_in = step_ff + STEP_BITS'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         held_ff  <= '0;
         cnt_ff   <= '0;
         sum_ff   <= '0;
         err_ff   <= '0;
         dis_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         err_ff   <= err_in;
         dis_ff   <= dis_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      acc_ff      <= acc_in;
      tmp_ff      <= tmp_in;
      step_ff     <= step_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      quo_ff      <= quo_in;
      rpt_en_ff   <= rpt_en_in;
      rstatus_ff  <= rstatus_in;
      accepted_ff <= accepted_in;
      rejected_ff <= rejected_in;
      adopted_ff  <= adopted_in;
   end

   // result word, read in the done state
   assign result.held_range_mm    = held_ff;
   assign result.report           = rpt_en_ff & held_gt_min;
   assign result.report_status    = rstatus_ff;
   assign result.accepted         = accepted_ff;
   assign result.jump_rejected    = rejected_ff;
   assign result.jump_adopted     = adopted_ff;
   assign result.disabled         = dis_ff;

   assign status.idle = (state_ff == ST_IDLE);
   assign status.done = (state_ff == ST_DONE);

endmodule

`default_nettype wire
